[hdl/cri_pkg.sv]
// Shared constants, codes and control types for the color ramp interpolator.
`timescale 1ns / 1ps
`default_nettype none
package cri_pkg;

    localparam int DEPTH   = 16;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = AW + 1;
    localparam int FB      = 16;
    localparam int CH_W    = 16;
    localparam int CRD_W   = FB + 1;
    localparam int COLOR_W = 4 * CH_W;
    localparam int PROD_W  = CRD_W + CW;
    localparam int REM_W   = CRD_W + 1;
    localparam int BPROD_W = 2 * CRD_W + 1;
    localparam logic [CRD_W-1:0] ONE = CRD_W'(1) << FB;

    typedef enum logic [2:0] {
        MODE_CLEAR      = 3'd0,
        MODE_SET        = 3'd1,
        MODE_APPEND     = 3'd2,
        MODE_APPEND_POS = 3'd3,
        MODE_NEAREST    = 3'd4,
        MODE_LINEAR     = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_MUL, S_IDX, S_POS0, S_POS1, S_SCAN, S_DIV,
        S_RDA, S_RDB, S_RDC, S_BMUL, S_BADD, S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic mul;
        logic idx;
        logic pos0;
        logic pos1;
        logic scan;
        logic div;
        logic rda;
        logic rdb;
        logic rdc;
        logic bmul;
        logic badd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  empty;
        logic  pos_mode;
        logic  single;
        logic  hit;
        logic  scan_last;
        logic  div_last;
        logic  blend_last;
        logic  out_free;
    } t_sts;

endpackage
`default_nettype wire

[hdl/cri_ctrl.sv]
// Command sequencer for the color ramp interpolator.
`timescale 1ns / 1ps
`default_nettype none
module cri_ctrl
    import cri_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: begin
                if (i_sts.mode == MODE_NEAREST) begin
                    n_state = i_sts.empty ? S_FINISH : S_MUL;
                end else if (i_sts.mode == MODE_LINEAR) begin
                    if (i_sts.empty) n_state = S_FINISH;
                    else if (i_sts.pos_mode) n_state = i_sts.single ? S_FINISH : S_POS0;
                    else n_state = S_MUL;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_MUL:  n_state = S_IDX;
            S_IDX:  n_state = S_RDA;
            S_POS0: n_state = S_POS1;
            S_POS1: n_state = S_SCAN;
            S_SCAN: begin
                if (i_sts.hit) n_state = S_DIV;
                else if (i_sts.scan_last) n_state = S_FINISH;
            end
            S_DIV:  if (i_sts.div_last) n_state = S_RDA;
            S_RDA:  n_state = S_RDB;
            S_RDB:  n_state = S_RDC;
            S_RDC:  n_state = S_BMUL;
            S_BMUL: n_state = S_BADD;
            S_BADD: n_state = i_sts.blend_last ? S_FINISH : S_BMUL;
            S_FINISH: if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_EXEC:   o_cmd.exec = 1'b1;
            S_MUL:    o_cmd.mul = 1'b1;
            S_IDX:    o_cmd.idx = 1'b1;
            S_POS0:   o_cmd.pos0 = 1'b1;
            S_POS1:   o_cmd.pos1 = 1'b1;
            S_SCAN:   o_cmd.scan = 1'b1;
            S_DIV:    o_cmd.div = 1'b1;
            S_RDA:    o_cmd.rda = 1'b1;
            S_RDB:    o_cmd.rdb = 1'b1;
            S_RDC:    o_cmd.rdc = 1'b1;
            S_BMUL:   o_cmd.bmul = 1'b1;
            S_BADD:   o_cmd.badd = 1'b1;
            S_FINISH: o_cmd.out_load = i_sts.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

[hdl/cri_dp.sv]
// Datapath: palette stores, counters, span search, divider, blender, output word.
`timescale 1ns / 1ps
`default_nettype none
module cri_dp
    import cri_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  wire  [2:0]        i_mode,
    input  wire  [7:0]        i_index,
    input  wire  [CH_W-1:0]   i_red_in,
    input  wire  [CH_W-1:0]   i_green_in,
    input  wire  [CH_W-1:0]   i_blue_in,
    input  wire  [CH_W-1:0]   i_alpha_in,
    input  wire  [CRD_W-1:0]  i_coordinate,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic [CH_W-1:0]   o_red_out,
    output logic [CH_W-1:0]   o_green_out,
    output logic [CH_W-1:0]   o_blue_out,
    output logic [CH_W-1:0]   o_alpha_out,
    output logic [1:0]        o_status,
    output logic [CW-1:0]     o_entry_count,
    output logic              o_has_positions
);

    logic [COLOR_W-1:0] r_cmem [DEPTH];
    logic [CRD_W-1:0]   r_pmem [DEPTH];
    logic [DEPTH-1:0]   r_cvalid;
    logic [CW-1:0]      r_cc, r_pc;

    t_mode              r_mode;
    logic [7:0]         r_idx;
    logic [COLOR_W-1:0] r_color;
    logic [CRD_W-1:0]   r_coord, r_t;
    t_status            r_stat;

    logic [PROD_W-1:0]  r_prod;
    logic [AW-1:0]      r_lo, r_hi;
    logic [CRD_W-1:0]   r_f;
    logic [CW-1:0]      r_i;
    logic [CRD_W-1:0]   r_pa, r_pdata;
    logic [REM_W-1:0]   r_rem;
    logic [CRD_W-1:0]   r_div;
    logic [FB-1:0]      r_q;
    logic [CW-1:0]      r_dcnt;
    logic [COLOR_W-1:0] r_crdata, r_ca, r_cb, r_res;
    logic               r_crvalid;
    logic [1:0]         r_k;
    logic signed [BPROD_W-1:0] r_bprod;

    logic [COLOR_W-1:0] r_out_color;
    t_status            r_out_stat;
    logic [CW-1:0]      r_out_cc;
    logic               r_out_hp;
    logic               r_out_valid;

    // color store write port and store read addresses
    logic               c_we;
    logic [AW-1:0]      c_waddr;
    logic [AW-1:0]      c_raddr, p_raddr;

    logic               set_ok, app_full, hit;
    logic [CW-1:0]      mult, nidx, nn, ul;
    logic [REM_W-1:0]   rem_sub;
    logic               rem_ge;
    logic [CH_W-1:0]    ca_k, cb_k;
    logic signed [CRD_W-1:0] d_k;
    logic [COLOR_W-1:0] crd;

    assign set_ok   = r_idx < {3'b000, r_cc};
    assign app_full = (r_cc >= CW'(DEPTH)) || (r_pc >= CW'(DEPTH));
    assign hit      = (r_pa != r_pdata) && (r_t >= r_pa) && (r_t <= r_pdata);
    assign mult     = (r_mode == MODE_NEAREST) ? r_cc : r_cc - 1'b1;
    assign nidx     = r_prod[FB +: CW];
    assign nn       = r_cc - 1'b1;
    assign ul       = r_prod[FB +: CW];
    assign rem_ge   = r_rem >= {1'b0, r_div};
    assign rem_sub  = rem_ge ? r_rem - {1'b0, r_div} : r_rem;
    assign ca_k     = r_ca[r_k * CH_W +: CH_W];
    assign cb_k     = r_cb[r_k * CH_W +: CH_W];
    assign d_k      = $signed({1'b0, cb_k}) - $signed({1'b0, ca_k});
    assign crd      = r_crvalid ? r_crdata : '0;

    always_comb begin
        c_we = 1'b0;
        c_waddr = r_idx[AW-1:0];
        if (i_cmd.exec) begin
            if (r_mode == MODE_SET) begin
                c_we = set_ok;
            end else if (r_mode == MODE_APPEND || r_mode == MODE_APPEND_POS) begin
                c_we = !app_full;
                c_waddr = r_cc[AW-1:0];
            end
        end
    end

    always_comb begin
        c_raddr = i_cmd.rdb ? r_hi : r_lo;
        p_raddr = i_cmd.pos0 ? '0 : AW'(r_i + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (c_we) r_cmem[c_waddr] <= r_color;
        if (i_cmd.exec && r_mode == MODE_APPEND_POS && !app_full) begin
            r_pmem[r_pc[AW-1:0]] <= r_coord;
        end
        r_crdata  <= r_cmem[c_raddr];
        r_crvalid <= r_cvalid[c_raddr];
        r_pdata   <= r_pmem[p_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
            r_cc <= '0;
            r_pc <= '0;
        end else begin
            if (c_we) r_cvalid[c_waddr] <= 1'b1;
            if (i_cmd.exec) begin
                unique case (r_mode)
                    MODE_CLEAR: begin
                        r_cvalid <= '0;
                        r_cc <= (r_idx > 8'(DEPTH)) ? CW'(DEPTH) : r_idx[CW-1:0];
                        r_pc <= '0;
                    end
                    MODE_APPEND, MODE_APPEND_POS: begin
                        if (!app_full) begin
                            r_cc <= r_cc + 1'b1;
                            if (r_mode == MODE_APPEND_POS) r_pc <= r_pc + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= t_mode'(i_mode);
            r_idx   <= i_index;
            r_color <= {i_alpha_in, i_blue_in, i_green_in, i_red_in};
            r_coord <= i_coordinate;
            r_t     <= (i_coordinate > ONE) ? ONE : i_coordinate;
            r_stat  <= ST_OK;
            r_res   <= '0;
        end
        if (i_cmd.exec) begin
            unique case (r_mode)
                MODE_CLEAR: if (r_idx > 8'(DEPTH)) r_stat <= ST_FULL;
                MODE_SET: if (!set_ok) r_stat <= ST_RANGE;
                MODE_APPEND, MODE_APPEND_POS: if (app_full) r_stat <= ST_FULL;
                MODE_NEAREST: if (r_cc == '0) r_stat <= ST_RANGE;
                MODE_LINEAR: begin
                    if (r_cc == '0 || (o_sts.pos_mode && r_cc == CW'(1))) r_stat <= ST_RANGE;
                end
                default: ;
            endcase
        end
        if (i_cmd.mul) r_prod <= PROD_W'(r_t) * PROD_W'(mult);
        if (i_cmd.idx) begin
            if (r_mode == MODE_NEAREST) begin
                r_lo <= (nidx >= r_cc) ? nn[AW-1:0] : nidx[AW-1:0];
                r_hi <= (nidx >= r_cc) ? nn[AW-1:0] : nidx[AW-1:0];
                r_f  <= '0;
            end else begin
                r_lo <= ul[AW-1:0];
                r_hi <= (ul == nn) ? ul[AW-1:0] : AW'(ul + 1'b1);
                r_f  <= {1'b0, r_prod[FB-1:0]};
            end
        end
        if (i_cmd.pos0) r_i <= '0;
        if (i_cmd.pos1) begin
            r_pa <= r_pdata;
            r_i  <= CW'(1);
        end
        if (i_cmd.scan) begin
            if (hit) begin
                r_lo   <= AW'(r_i - 1'b1);
                r_hi   <= r_i[AW-1:0];
                r_rem  <= {1'b0, r_t - r_pa};
                r_div  <= r_pdata - r_pa;
                r_q    <= '0;
                r_dcnt <= '0;
            end else begin
                r_pa <= r_pdata;
                r_i  <= r_i + 1'b1;
                if (o_sts.scan_last) r_stat <= ST_RANGE;
            end
        end
        if (i_cmd.div) begin
            r_q    <= {r_q[FB-2:0], rem_ge};
            r_rem  <= {rem_sub[REM_W-2:0], 1'b0};
            r_dcnt <= r_dcnt + 1'b1;
            if (o_sts.div_last) r_f <= {r_q, rem_ge};
        end
        if (i_cmd.rdb) r_ca <= crd;
        if (i_cmd.rdc) begin
            r_cb <= crd;
            r_k  <= '0;
        end
        if (i_cmd.bmul) r_bprod <= d_k * $signed({1'b0, r_f});
        if (i_cmd.badd) begin
            r_res[r_k * CH_W +: CH_W] <= ca_k + r_bprod[FB +: CH_W];
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_color <= r_res;
            r_out_stat  <= r_stat;
            r_out_cc    <= r_cc;
            r_out_hp    <= r_pc != '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.mode       = r_mode;
        o_sts.empty      = r_cc == '0;
        o_sts.pos_mode   = (r_pc != '0) && (r_pc == r_cc);
        o_sts.single     = r_cc == CW'(1);
        o_sts.hit        = hit;
        o_sts.scan_last  = (r_i + 1'b1) >= r_cc;
        o_sts.div_last   = r_dcnt == CW'(FB);
        o_sts.blend_last = r_k == 2'd3;
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid     = r_out_valid;
    assign o_red_out       = r_out_color[0 +: CH_W];
    assign o_green_out     = r_out_color[CH_W +: CH_W];
    assign o_blue_out      = r_out_color[2*CH_W +: CH_W];
    assign o_alpha_out     = r_out_color[3*CH_W +: CH_W];
    assign o_status        = r_out_stat;
    assign o_entry_count   = r_out_cc;
    assign o_has_positions = r_out_hp;

    a_pc_le_cc: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_pc <= r_cc)
        else $error("position count above color count");
    a_cc_max: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cc <= CW'(DEPTH))
        else $error("color count above depth");
    a_f_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div && o_sts.div_last |=> r_f <= ONE)
        else $error("span fraction above one");

endmodule
`default_nettype wire

[hdl/color_ramp_interpolator.sv]
// Top level of the color ramp interpolator: sequencer plus datapath.
//
//  channel   direction  handshake                 word
//  in        input      i_in_valid / o_in_stall   mode, index, rgba, coordinate
//  out       output     o_out_valid / i_out_stall rgba, status, count, positions
//
// Commands pass through load, execute and finish; nearest and uniform linear lookups
// add multiply, index, three reads and a four-channel blend. Positioned linear lookups
// replace multiply and index by a one-span-per-cycle position scan and a bit-serial divider.
// Reset (i_rst_n low, synchronous) empties the palette and the output word.
// A new word is taken while the previous result still waits under i_out_stall.
`timescale 1ns / 1ps
`default_nettype none
module color_ramp_interpolator
    import cri_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire  [2:0]        i_mode,
    input  wire  [7:0]        i_index,
    input  wire  [CH_W-1:0]   i_red_in,
    input  wire  [CH_W-1:0]   i_green_in,
    input  wire  [CH_W-1:0]   i_blue_in,
    input  wire  [CH_W-1:0]   i_alpha_in,
    input  wire  [CRD_W-1:0]  i_coordinate,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic [CH_W-1:0]   o_red_out,
    output logic [CH_W-1:0]   o_green_out,
    output logic [CH_W-1:0]   o_blue_out,
    output logic [CH_W-1:0]   o_alpha_out,
    output logic [1:0]        o_status,
    output logic [CW-1:0]     o_entry_count,
    output logic              o_has_positions
);

    t_cmd cmd;
    t_sts sts;

    cri_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cri_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_mode          (i_mode),
        .i_index         (i_index),
        .i_red_in        (i_red_in),
        .i_green_in      (i_green_in),
        .i_blue_in       (i_blue_in),
        .i_alpha_in      (i_alpha_in),
        .i_coordinate    (i_coordinate),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_red_out       (o_red_out),
        .o_green_out     (o_green_out),
        .o_blue_out      (o_blue_out),
        .o_alpha_out     (o_alpha_out),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count),
        .o_has_positions (o_has_positions)
    );

endmodule
`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the color ramp interpolator: predicted palette results.
`timescale 1ns / 1ps
module tb_top;
    import cri_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [2:0]        i_mode;
    logic [7:0]        i_index;
    logic [CH_W-1:0]   i_red_in, i_green_in, i_blue_in, i_alpha_in;
    logic [CRD_W-1:0]  i_coordinate;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [CH_W-1:0]   o_red_out, o_green_out, o_blue_out, o_alpha_out;
    logic [1:0]        o_status;
    logic [CW-1:0]     o_entry_count;
    logic              o_has_positions;

    color_ramp_interpolator u_dut (.*);

    typedef struct {
        logic [CH_W-1:0] r, g, b, a;
        logic [1:0]      st;
        logic [CW-1:0]   cnt;
        logic            hp;
    } t_lookup;

    t_lookup           lookup_q[$];
    logic [63:0]       ramp_colors[DEPTH];
    logic [CRD_W-1:0]  ramp_stops[DEPTH];
    int                n_colors, n_stops;
    int                errors, words_sent, words_checked;
    int                send_idle_pct, recv_stall_pct;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [63:0] mix_colors(logic [63:0] ca, logic [63:0] cb,
                                               longint unsigned f);
        logic [63:0] res;
        longint unsigned a, b, v;
        res = 0;
        for (int k = 0; k < 4; k++) begin
            a = (ca >> (16 * k)) & 16'hFFFF;
            b = (cb >> (16 * k)) & 16'hFFFF;
            v = (a * (65536 - f) + b * f) >> 16;
            res |= (v & 16'hFFFF) << (16 * k);
        end
        return res;
    endfunction

    function automatic void apply_command(logic [2:0] m, logic [7:0] idx,
                                          logic [63:0] col, logic [CRD_W-1:0] crd);
        t_lookup e;
        longint unsigned t, lo, hi, f, n, pa, pb, i;
        logic [63:0] c;
        logic found;
        t = crd > ONE ? 65536 : crd;
        c = 0;
        e.st = ST_OK;
        case (m)
            MODE_CLEAR: begin
                for (int k = 0; k < DEPTH; k++) ramp_colors[k] = 0;
                if (idx > DEPTH) begin
                    n_colors = DEPTH;
                    e.st = ST_FULL;
                end else n_colors = idx;
                n_stops = 0;
            end
            MODE_SET: begin
                if (idx < n_colors) ramp_colors[idx] = col;
                else e.st = ST_RANGE;
            end
            MODE_APPEND, MODE_APPEND_POS: begin
                if (n_colors >= DEPTH || n_stops >= DEPTH) e.st = ST_FULL;
                else begin
                    ramp_colors[n_colors] = col;
                    n_colors++;
                    if (m == MODE_APPEND_POS) begin
                        ramp_stops[n_stops] = crd;
                        n_stops++;
                    end
                end
            end
            MODE_NEAREST: begin
                if (n_colors == 0) e.st = ST_RANGE;
                else begin
                    i = (t * n_colors) >> 16;
                    if (i >= n_colors) i = n_colors - 1;
                    c = ramp_colors[i];
                end
            end
            MODE_LINEAR: begin
                if (n_colors == 0) e.st = ST_RANGE;
                else if (n_stops > 0 && n_stops == n_colors) begin
                    found = 0;
                    for (int k = 0; k + 1 < n_colors && !found; k++) begin
                        pa = ramp_stops[k];
                        pb = ramp_stops[k + 1];
                        if (pa != pb && t >= pa && t <= pb) begin
                            f = ((t - pa) << 16) / (pb - pa);
                            c = mix_colors(ramp_colors[k], ramp_colors[k + 1], f);
                            found = 1;
                        end
                    end
                    if (!found) e.st = ST_RANGE;
                end else begin
                    n = n_colors - 1;
                    if (n == 0) c = ramp_colors[0];
                    else begin
                        lo = (t * n) >> 16;
                        if (lo > n) lo = n;
                        f = t * n - (lo << 16);
                        hi = lo + 1 > n ? n : lo + 1;
                        if (f > 65536) f = 65536;
                        c = mix_colors(ramp_colors[lo], ramp_colors[hi], f);
                    end
                end
            end
            default: ;
        endcase
        e.r = c[15:0];
        e.g = c[31:16];
        e.b = c[47:32];
        e.a = c[63:48];
        e.cnt = CW'(n_colors);
        e.hp = n_stops > 0;
        lookup_q.push_back(e);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d (word %0d)", what, got, want, words_checked);
        errors++;
    endtask

    task automatic send_word(logic [2:0] m, logic [7:0] idx, logic [63:0] col,
                             logic [CRD_W-1:0] crd);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1;
        i_mode       <= m;
        i_index      <= idx;
        i_red_in     <= col[15:0];
        i_green_in   <= col[31:16];
        i_blue_in    <= col[47:32];
        i_alpha_in   <= col[63:48];
        i_coordinate <= crd;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_command(m, idx, col, crd);
        words_sent++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_lookup e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (lookup_q.size() == 0) begin
                $display("unexpected result word");
                errors++;
            end else begin
                e = lookup_q.pop_front();
                if (o_red_out !== e.r) report_mismatch("red", o_red_out, e.r);
                if (o_green_out !== e.g) report_mismatch("green", o_green_out, e.g);
                if (o_blue_out !== e.b) report_mismatch("blue", o_blue_out, e.b);
                if (o_alpha_out !== e.a) report_mismatch("alpha", o_alpha_out, e.a);
                if (o_status !== e.st) report_mismatch("status", o_status, e.st);
                if (o_entry_count !== e.cnt) report_mismatch("count", o_entry_count, e.cnt);
                if (o_has_positions !== e.hp)
                    report_mismatch("has_positions", o_has_positions, e.hp);
            end
            words_checked++;
        end
    end

    function automatic logic [63:0] rand_color();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [CRD_W-1:0] rand_coord();
        case ($urandom_range(5))
            0: return ONE;
            1: return 0;
            2: return CRD_W'($urandom_range(65537, 131071));
            default: return CRD_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic test_directed();
        send_word(MODE_LINEAR, 0, 0, 100);
        send_word(MODE_NEAREST, 0, 0, 100);
        send_word(MODE_SET, 0, '1, 0);
        send_word(MODE_APPEND, 0, 64'h0123_4567_89AB_CDEF, 0);
        send_word(MODE_LINEAR, 0, 0, 17'h1FFFF);
        send_word(MODE_APPEND, 0, '1, 0);
        send_word(MODE_LINEAR, 0, 0, 32768);
        send_word(MODE_NEAREST, 0, 0, ONE);
        send_word(MODE_SET, 5, '1, 0);
        send_word(3'd6, 8'hFF, '1, '1);
        send_word(3'd7, 0, 0, 0);
        send_word(MODE_CLEAR, 8'hFF, 0, 0);
        send_word(MODE_APPEND, 0, '1, 0);
        send_word(MODE_SET, 15, '1, 0);
        send_word(MODE_LINEAR, 0, 0, 40000);
        send_word(MODE_CLEAR, 0, 0, 0);
        send_word(MODE_APPEND_POS, 0, '1, 20000);
        send_word(MODE_APPEND_POS, 0, 0, 20000);
        send_word(MODE_APPEND_POS, 0, 64'hFFFF_0000_FFFF_0000, 50000);
        send_word(MODE_APPEND_POS, 0, 64'h1234_5678_9ABC_DEF0, 10000);
        send_word(MODE_LINEAR, 0, 0, 20000);
        send_word(MODE_LINEAR, 0, 0, 35000);
        send_word(MODE_LINEAR, 0, 0, 60000);
        send_word(MODE_APPEND, 0, '1, 0);
        send_word(MODE_LINEAR, 0, 0, 30000);
    endtask

    task automatic test_random(int n_words);
        int k, pick;
        logic [CRD_W-1:0] p;
        for (k = 0; k < n_words; k++) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                send_word(MODE_CLEAR, ($urandom_range(9) == 0) ? 8'($urandom())
                          : 8'($urandom_range(0, DEPTH)), rand_color(), rand_coord());
            end else if (pick < 12 && n_stops == 0 && n_colors == 0) begin
                p = CRD_W'($urandom_range(0, 8000));
                repeat ($urandom_range(1, DEPTH)) begin
                    send_word(MODE_APPEND_POS, 0, rand_color(), p);
                    p = ($urandom_range(7) == 0) ? rand_coord()
                        : CRD_W'(p + $urandom_range(0, 12000));
                end
            end else if (pick < 22) begin
                send_word(MODE_SET, ($urandom_range(3) == 0) ? 8'($urandom())
                          : 8'($urandom_range(0, DEPTH)), rand_color(), rand_coord());
            end else if (pick < 30) begin
                send_word(MODE_APPEND, 8'($urandom()), rand_color(), rand_coord());
            end else if (pick < 35) begin
                send_word(MODE_APPEND_POS, 8'($urandom()), rand_color(), rand_coord());
            end else if (pick < 55) begin
                send_word(MODE_NEAREST, 8'($urandom()), rand_color(), rand_coord());
            end else if (pick < 97) begin
                send_word(MODE_LINEAR, 8'($urandom()), rand_color(), rand_coord());
            end else begin
                send_word(3'($urandom_range(6, 7)), 8'($urandom()), rand_color(),
                          rand_coord());
            end
        end
    endtask

    task automatic drain();
        int guard;
        i_in_valid <= 0;
        guard = 0;
        while (lookup_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int n_words);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        test_random(n_words);
        drain();
    endtask

    initial begin
        i_rst_n = 0;
        i_in_valid = 0;
        i_out_stall = 0;
        i_mode = 0;
        i_index = 0;
        i_red_in = 0;
        i_green_in = 0;
        i_blue_in = 0;
        i_alpha_in = 0;
        i_coordinate = 0;
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        n_colors = 0;
        n_stops = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int k = 0; k < DEPTH; k++) begin
            ramp_colors[k] = 0;
            ramp_stops[k] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        drain();
        run_phase(0, 0, 130);
        run_phase(88, 0, 110);
        run_phase(0, 88, 110);
        run_phase(16, 16, 130);
        if (lookup_q.size() != 0) begin
            $display("%0d expected words never arrived", lookup_q.size());
            errors++;
        end
        $display("sent %0d command words, checked %0d results over four idle/stall phases",
                 words_sent, words_checked);
        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
